### rtl/assert_macros.svh
// assertion macros for the rtl files, included by the top level
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define HMML_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hmml assertion failed");

// next-cycle implication, held off during reset
`define HMML_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hmml assertion failed");

`endif

### rtl/hmml_pkg.sv
// types and constants of the hourly min/max/mean logger
// no dependencies; used by every rtl module of the block but hmml_ram
`default_nettype none

package hmml_pkg;

  localparam logic [31:0] HOUR_SECONDS = 32'd3600;
  localparam logic [31:0] TWO_HOURS    = 32'd7200;
  localparam logic [15:0] SAMPLE_LIMIT = 16'hFFFF;

  // configuration register indexes
  localparam int          CFG_IDX_W        = 1;
  localparam logic [0:0]  CFG_MIN_SENTINEL = 1'b0;
  localparam logic [0:0]  CFG_MAX_SENTINEL = 1'b1;

  localparam logic signed [15:0] MIN_SENTINEL_RST = 16'sd9990;
  localparam logic signed [15:0] MAX_SENTINEL_RST = -16'sd9990;

  // func codes
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic               func;
    logic [31:0]        hour_tag;
    logic signed [15:0] temp_tenths;
    logic [9:0]         read_slot;
  } in_word_t;

  typedef struct packed {
    logic               hour_closed;
    logic signed [15:0] out_min;
    logic signed [15:0] out_max;
    logic signed [15:0] out_avg;
    logic               entry_valid;
    logic [10:0]        held_count;
    logic [9:0]         oldest_slot;
    logic [31:0]        latest_hour_time;
    logic [15:0]        open_samples;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] mn;
    logic signed [15:0] mx;
    logic signed [15:0] avg;
  } ring_entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_issue;
    logic rd_take;
    logic div_start;
    logic div_step;
    logic push_first;
    logic push_fill;
    logic update;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic closes;
    logic div_last;
    logic fill_more;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/hmml_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module hmml_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/hmml_dp.sv
// datapath: sentinels, open-hour accumulator, serial divider, ring pointers and ring ram
// depends on hmml_pkg and hmml_ram
`default_nettype none

module hmml_dp #(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [hmml_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data,
  input  wire hmml_pkg::in_word_t            in_word,
  input  wire hmml_pkg::ctrl_cmd_t           cmd,
  output hmml_pkg::dp_stat_t                 stat,
  output hmml_pkg::out_word_t                out_word
);

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);

  // sentinels
  logic signed [15:0] min_sent_r, max_sent_r;

  // captured word
  hmml_pkg::in_word_t in_r;

  // open hour accumulator
  logic [31:0]        open_hour_r;
  logic [31:0]        hour_sum_r;
  logic [15:0]        hour_samples_r;
  logic signed [15:0] hour_min_r, hour_max_r;
  logic [31:0]        newest_r;

  // ring pointers
  logic [SLOT_W-1:0]  ws_r;
  logic [CNT_W-1:0]   held_r;

  // result of the current word
  logic               res_closed_r, res_valid_r;
  hmml_pkg::ring_entry_t res_r;

  // divider
  logic [15:0]        div_rem_r;
  logic [31:0]        div_quo_r;
  logic               div_neg_r;
  logic [4:0]         div_cnt_r;

  // skipped-hour fill
  logic [31:0]        fill_acc_r;
  logic [CNT_W-1:0]   fill_n_r;

  hmml_pkg::out_word_t out_r;

  // ring ram
  logic                  ram_we, ram_re;
  logic [SLOT_W-1:0]     ram_raddr;
  hmml_pkg::ring_entry_t ram_wdata, ram_rdata;

  // ---------------------------------------------------------------
  // combinational helpers
  logic [31:0]        slot32;
  logic               rd_ok;
  logic [16:0]        rem_sh;
  logic               div_ge;
  logic [31:0]        quo_signed;
  logic signed [15:0] avg_final;
  logic [31:0]        sum_mag;
  logic               closes;
  logic [31:0]        held32, ws32;
  logic [SLOT_W-1:0]  ws_inc;
  logic [CNT_W-1:0]   held_inc;

  // update-step values
  logic [31:0]        base_sum;
  logic [15:0]        base_samples;
  logic signed [15:0] base_min, base_max;

  assign slot32 = 32'(in_r.read_slot);
  assign held32 = 32'(held_r);
  assign ws32   = 32'(ws_r);
  assign rd_ok  = (slot32 < held32) && (slot32 < 32'(RING_DEPTH));

  assign closes = (in_r.func == hmml_pkg::FUNC_ADD) && (open_hour_r != 32'd0) &&
                  (in_r.hour_tag != open_hour_r);

  assign rem_sh = {div_rem_r, div_quo_r[31]};
  assign div_ge = rem_sh >= {1'b0, hour_samples_r};

  assign quo_signed = div_neg_r ? (32'd0 - div_quo_r) : div_quo_r;
  assign avg_final  = (hour_samples_r == 16'd0) ? hour_min_r : $signed(quo_signed[15:0]);
  assign sum_mag    = hour_sum_r[31] ? (32'd0 - hour_sum_r) : hour_sum_r;

  assign ws_inc   = (ws_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : ws_r + 1'b1;
  assign held_inc = (held_r == CNT_W'(RING_DEPTH)) ? held_r : held_r + 1'b1;

  assign base_sum     = closes ? 32'd0 : hour_sum_r;
  assign base_samples = closes ? 16'd0 : hour_samples_r;
  assign base_min     = closes ? min_sent_r : hour_min_r;
  assign base_max     = closes ? max_sent_r : hour_max_r;

  assign stat.is_read   = (in_r.func == hmml_pkg::FUNC_READ);
  assign stat.closes    = closes;
  assign stat.div_last  = (div_cnt_r == 5'd31);
  assign stat.fill_more = (32'(fill_n_r) < 32'(RING_DEPTH)) &&
                          (fill_acc_r >= hmml_pkg::TWO_HOURS);

  // ram ports
  always_comb begin
    ram_we    = cmd.push_first || cmd.push_fill;
    ram_wdata = res_r;
    if (cmd.push_first) begin
      ram_wdata.mn  = hour_min_r;
      ram_wdata.mx  = hour_max_r;
      ram_wdata.avg = avg_final;
    end
    ram_re    = cmd.rd_issue;
    ram_raddr = rd_ok ? slot32[SLOT_W-1:0] : '0;
  end

  hmml_ram #(
    .WIDTH ($bits(hmml_pkg::ring_entry_t)),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ws_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------
  // sentinels, accumulator and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sent_r     <= hmml_pkg::MIN_SENTINEL_RST;
      max_sent_r     <= hmml_pkg::MAX_SENTINEL_RST;
      open_hour_r    <= 32'd0;
      hour_sum_r     <= 32'd0;
      hour_samples_r <= 16'd0;
      hour_min_r     <= hmml_pkg::MIN_SENTINEL_RST;
      hour_max_r     <= hmml_pkg::MAX_SENTINEL_RST;
      newest_r       <= 32'd0;
      ws_r           <= '0;
      held_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          hmml_pkg::CFG_MIN_SENTINEL: min_sent_r <= $signed(cfg_data);
          hmml_pkg::CFG_MAX_SENTINEL: max_sent_r <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (ram_we) begin
        ws_r   <= ws_inc;
        held_r <= held_inc;
      end
      if (cmd.update) begin
        if (closes) begin
          newest_r <= in_r.hour_tag - hmml_pkg::HOUR_SECONDS;
        end else if (open_hour_r == 32'd0) begin
          newest_r <= in_r.hour_tag;
        end
        open_hour_r <= in_r.hour_tag;
        if (base_samples != hmml_pkg::SAMPLE_LIMIT) begin
          hour_samples_r <= base_samples + 16'd1;
          hour_sum_r     <= base_sum + 32'($signed(in_r.temp_tenths));
        end else begin
          hour_samples_r <= base_samples;
          hour_sum_r     <= base_sum;
        end
        hour_min_r <= (in_r.temp_tenths < base_min) ? in_r.temp_tenths : base_min;
        hour_max_r <= (in_r.temp_tenths > base_max) ? in_r.temp_tenths : base_max;
      end
    end
  end

  // ---------------------------------------------------------------
  // payload registers: captured word, result, divider, fill, output
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r         <= in_word;
      res_closed_r <= 1'b0;
      res_valid_r  <= 1'b0;
      res_r        <= '0;
    end
    if (cmd.rd_issue) begin
      res_valid_r <= rd_ok;
    end
    if (cmd.rd_take && res_valid_r) begin
      res_r <= ram_rdata;
    end
    if (cmd.div_start) begin
      div_rem_r <= 16'd0;
      div_quo_r <= sum_mag;
      div_neg_r <= hour_sum_r[31];
      div_cnt_r <= 5'd0;
    end else if (cmd.div_step) begin
      div_rem_r <= div_ge ? 16'(rem_sh - {1'b0, hour_samples_r}) : rem_sh[15:0];
      div_quo_r <= {div_quo_r[30:0], div_ge};
      div_cnt_r <= div_cnt_r + 5'd1;
    end
    if (cmd.push_first) begin
      res_closed_r <= 1'b1;
      res_r        <= ram_wdata;
      fill_acc_r   <= (in_r.hour_tag > open_hour_r) ? (in_r.hour_tag - open_hour_r) : 32'd0;
      fill_n_r     <= CNT_W'(1);
    end else if (cmd.push_fill) begin
      fill_acc_r <= fill_acc_r - hmml_pkg::HOUR_SECONDS;
      fill_n_r   <= fill_n_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_r.hour_closed      <= res_closed_r;
      out_r.out_min          <= res_r.mn;
      out_r.out_max          <= res_r.mx;
      out_r.out_avg          <= res_r.avg;
      out_r.entry_valid      <= res_valid_r;
      out_r.held_count       <= held32[10:0];
      out_r.oldest_slot      <= (held32 < 32'(RING_DEPTH)) ? 10'd0 : ws32[9:0];
      out_r.latest_hour_time <= newest_r;
      out_r.open_samples     <= hour_samples_r;
    end
  end

  assign out_word = out_r;

endmodule

`default_nettype wire

### rtl/hmml_ctrl.sv
// controller state machine: sequences accept, read, divide, ring fill, update and output
// depends on hmml_pkg
`default_nettype none

module hmml_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire hmml_pkg::dp_stat_t  stat,
  output hmml_pkg::ctrl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_RDDAT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.is_read) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RDDAT;
        end else if (stat.closes) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_RDDAT: begin
        cmd.rd_take = 1'b1;
        state_nxt   = S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push_first = 1'b1;
        state_nxt      = S_FILL;
      end
      S_FILL: begin
        if (stat.fill_more) begin
          cmd.push_fill = 1'b1;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/hourly_min_max_mean_logger.sv
// top level of the hourly min/max/mean logger: controller, datapath and checks
// depends on hmml_pkg, hmml_ctrl, hmml_dp (with hmml_ram) and assert_macros.svh
`default_nettype none

// Hourly min/max/mean logger. Each input word either adds a temperature reading
// (func 0, tenths of a degree, tagged with the start of its hour in seconds) or reads
// one hourly entry from the ring (func 1). Every word yields exactly one output word.
// A reading whose hour tag differs from the open hour closes that hour: min, max and
// truncated mean are written to the ring, and each further whole hour skipped gets a
// copy, up to RING_DEPTH entries per close. One word is processed at a time and
// in_stall stays high while it is at work. A close is slowed by the one-bit-per-cycle
// mean divider (32 steps) and by the single ram write port writing one copy per cycle.
// The output register lets a new word be accepted while the last result waits.
// Sentinel writes on the cfg port take effect when a reading closes an hour; the
// first hour after reset starts from the reset sentinels.
// The ring ram holds undefined data after reset; only slots below held_count are
// ever returned.

module hourly_min_max_mean_logger #(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire hmml_pkg::in_word_t             in_word,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output hmml_pkg::out_word_t                 out_word,
  // configuration write port
  input  wire logic                           cfg_wr_en,
  input  wire logic [hmml_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_data
);

`include "assert_macros.svh"

  hmml_pkg::ctrl_cmd_t cmd;
  hmml_pkg::dp_stat_t  stat;

  // sequencing
  hmml_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // accumulator, divider, ring and output register
  hmml_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

  // an accepted word keeps the input side stalled on the next cycle
  `HMML_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // the output register is only loaded when its word has gone or is leaving
  `HMML_ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.load_out, !out_valid || !out_stall)
  // a result is never loaded in the cycle a new word is taken
  `HMML_ASSERT_IMPL(a_no_load_on_accept, clk, rst_n, cmd.load_out, !(in_valid && !in_stall))
  // ring writes happen only while a word is in work
  `HMML_ASSERT_IMPL(a_push_when_busy, clk, rst_n, cmd.push_first || cmd.push_fill, in_stall)

endmodule

`default_nettype wire

### bench/hourly_min_max_mean_logger_test.sv
`timescale 1ns / 1ps
// self-checking bench for the hourly min/max/mean logger: directed table, then random
// hours; outputs are held to pinned rows or an in-bench accumulator and ring log
// depends on hmml_pkg and the hourly_min_max_mean_logger rtl

module hourly_min_max_mean_logger_test;

  localparam int RING_DEPTH = 1024;
  // arbitrary first hour tag of the directed part
  localparam logic [31:0] BASE_HOUR = 32'd360000;
  localparam int PHASE_WORDS = 190;
  localparam int N_PHASES = 6;

  typedef struct {
    hmml_pkg::in_word_t  w;
    bit                  pinned;
    hmml_pkg::out_word_t want;
  } stim_row_t;

  logic                rst_n = 1'b0;
  logic                clk;
  logic                in_valid = 1'b0;
  logic                in_stall;
  hmml_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  hmml_pkg::out_word_t out_word;
  logic                cfg_wr_en = 1'b0;
  logic [hmml_pkg::CFG_IDX_W-1:0] cfg_index = hmml_pkg::CFG_MIN_SENTINEL;
  logic [15:0]         cfg_data = '0;

  // pinned expectation that travels with the word on the input channel
  bit                  row_pinned = 1'b0;
  hmml_pkg::out_word_t row_want = '0;

  // idling control: sender gaps and receiver stalls only while this is set
  bit idle_on = 1'b1;
  int stall_left = 0;

  // in-bench copy of the logger: sentinels, open hour accumulator and ring log
  logic signed [15:0] min_sent = hmml_pkg::MIN_SENTINEL_RST;
  logic signed [15:0] max_sent = hmml_pkg::MAX_SENTINEL_RST;
  logic [31:0]        open_tag = '0;
  int                 hr_sum = 0;
  int                 hr_n = 0;
  logic signed [15:0] hr_min = hmml_pkg::MIN_SENTINEL_RST;
  logic signed [15:0] hr_max = hmml_pkg::MAX_SENTINEL_RST;
  logic signed [15:0] ring_min [RING_DEPTH];
  logic signed [15:0] ring_max [RING_DEPTH];
  logic signed [15:0] ring_avg [RING_DEPTH];
  int                 wr_slot = 0;
  int                 held_n = 0;
  logic [31:0]        newest = '0;

  hmml_pkg::out_word_t due_reports [$];
  int                  n_fail = 0;

  // random hour sequence state
  logic [31:0] gen_hour = '0;
  int          gen_left = 0;

  hourly_min_max_mean_logger #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // expected output word for one accepted input word; advances the bench state
  function automatic hmml_pkg::out_word_t hour_report(hmml_pkg::in_word_t w);
    hmml_pkg::out_word_t r;
    logic signed [15:0] e_min, e_max, e_avg;
    longint span, n_copy;
    int k;
    r = '0;
    if (w.func == hmml_pkg::FUNC_READ) begin
      if (w.read_slot < held_n) begin
        r.entry_valid = 1'b1;
        r.out_min = ring_min[w.read_slot];
        r.out_max = ring_max[w.read_slot];
        r.out_avg = ring_avg[w.read_slot];
      end
    end else begin
      // a changed tag closes the open hour, unless no hour is open (tag zero)
      if (open_tag != '0 && w.hour_tag != open_tag) begin
        e_min = hr_min;
        e_max = hr_max;
        e_avg = (hr_n > 0) ? 16'(hr_sum / hr_n) : hr_min;
        r.hour_closed = 1'b1;
        r.out_min = e_min;
        r.out_max = e_max;
        r.out_avg = e_avg;
        // whole hours skipped get copies; earlier tags and short steps write one entry
        span = longint'({32'b0, w.hour_tag}) - longint'({32'b0, open_tag});
        n_copy = (span > 0) ? span / hmml_pkg::HOUR_SECONDS : 0;
        if (n_copy > RING_DEPTH) n_copy = RING_DEPTH;
        if (n_copy < 1) n_copy = 1;
        for (k = 0; k < n_copy; k++) begin
          ring_min[wr_slot] = e_min;
          ring_max[wr_slot] = e_max;
          ring_avg[wr_slot] = e_avg;
          wr_slot = (wr_slot + 1) % RING_DEPTH;
          if (held_n < RING_DEPTH) held_n++;
        end
        newest = w.hour_tag - hmml_pkg::HOUR_SECONDS;
        hr_sum = 0;
        hr_n = 0;
        hr_min = min_sent;
        hr_max = max_sent;
      end
      if (open_tag == '0) newest = w.hour_tag;
      open_tag = w.hour_tag;
      // count and sum freeze at the limit, min and max keep tracking
      if (hr_n < hmml_pkg::SAMPLE_LIMIT) begin
        hr_n++;
        hr_sum += w.temp_tenths;
      end
      if (w.temp_tenths < hr_min) hr_min = w.temp_tenths;
      if (w.temp_tenths > hr_max) hr_max = w.temp_tenths;
    end
    r.held_count = 11'(held_n);
    r.oldest_slot = (held_n < RING_DEPTH) ? '0 : 10'(wr_slot);
    r.latest_hour_time = newest;
    r.open_samples = 16'(hr_n);
    return r;
  endfunction

  task automatic check_field(string name, logic signed [32:0] want, logic signed [32:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  task automatic check_report(hmml_pkg::out_word_t got);
    hmml_pkg::out_word_t want;
    if (due_reports.size() == 0) begin
      $error("output word with no prediction pending");
      n_fail++;
      return;
    end
    want = due_reports.pop_front();
    check_field("hour_closed", want.hour_closed, got.hour_closed);
    check_field("out_min", want.out_min, got.out_min);
    check_field("out_max", want.out_max, got.out_max);
    check_field("out_avg", want.out_avg, got.out_avg);
    check_field("entry_valid", want.entry_valid, got.entry_valid);
    check_field("held_count", want.held_count, got.held_count);
    check_field("oldest_slot", want.oldest_slot, got.oldest_slot);
    check_field("latest_hour_time", want.latest_hour_time, got.latest_hour_time);
    check_field("open_samples", want.open_samples, got.open_samples);
  endtask

  // both channels sampled at the edge, before any nonblocking update lands
  always @(posedge clk) begin : channel_monitor
    hmml_pkg::out_word_t guess;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        guess = hour_report(in_word);
        due_reports.push_back(row_pinned ? row_want : guess);
      end
      if (out_valid && !out_stall) check_report(out_word);
    end
  end

  // receiver: random stall bursts while idling is on
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one word on the input channel; returns at the edge that accepts it
  task automatic send_word(hmml_pkg::in_word_t w, bit pinned, hmml_pkg::out_word_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    row_pinned <= pinned;
    row_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // lower valid and wait until every predicted word has come out
  task automatic drain_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  // sentinels only change with the logger idle
  task automatic set_sentinels(logic signed [15:0] lo, logic signed [15:0] hi);
    drain_words();
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= hmml_pkg::CFG_MIN_SENTINEL;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= hmml_pkg::CFG_MAX_SENTINEL;
    cfg_data <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_sent = lo;
    max_sent = hi;
  endtask

  // random word: mostly readings in runs per hour, some ring reads and noise
  task automatic send_random();
    hmml_pkg::in_word_t w;
    int pick;
    w.func = hmml_pkg::FUNC_ADD;
    w.read_slot = 10'($urandom);
    w.temp_tenths = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'(int'($urandom_range(0, 900)) - 300);
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      // ring read with junk in the unused fields; most slots in range
      w.func = hmml_pkg::FUNC_READ;
      w.hour_tag = $urandom;
      if (held_n > 0 && pick < 12) w.read_slot = 10'($urandom_range(0, held_n - 1));
    end else begin
      if (gen_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 68) gen_hour += hmml_pkg::HOUR_SECONDS;
        else if (pick < 80) gen_hour += hmml_pkg::HOUR_SECONDS * $urandom_range(2, 6);
        else if (pick < 86) gen_hour += $urandom_range(1, 3599);
        else if (pick < 92) gen_hour -= hmml_pkg::HOUR_SECONDS * $urandom_range(1, 3);
        else if (pick < 95) gen_hour = '0;
        else gen_hour = $urandom;
        gen_left = $urandom_range(1, 8);
      end
      gen_left--;
      w.hour_tag = gen_hour;
    end
    send_word(w, 1'b0, '0);
  endtask

  function automatic stim_row_t stim_row(logic f, logic [31:0] h, int t, int s,
                                         bit pin = 1'b0, hmml_pkg::out_word_t want = '0);
    stim_row_t r;
    r.w.func = f;
    r.w.hour_tag = h;
    r.w.temp_tenths = 16'(t);
    r.w.read_slot = 10'(s);
    r.pinned = pin;
    r.want = want;
    return r;
  endfunction

  function automatic hmml_pkg::out_word_t report_word(int closed, int mn, int mx, int avg,
                                                      int ok, int held, int oldest,
                                                      logic [31:0] latest, int opn);
    hmml_pkg::out_word_t r;
    r.hour_closed = 1'(closed);
    r.out_min = 16'(mn);
    r.out_max = 16'(mx);
    r.out_avg = 16'(avg);
    r.entry_valid = 1'(ok);
    r.held_count = 11'(held);
    r.oldest_slot = 10'(oldest);
    r.latest_hour_time = latest;
    r.open_samples = 16'(opn);
    return r;
  endfunction

  initial begin : stimulus
    stim_row_t steps [$];
    int p;
    // reads of the empty ring, field extremes included
    steps.push_back(stim_row(hmml_pkg::FUNC_READ, 32'd0, 0, 0, 1'b1, '0));
    steps.push_back(stim_row(hmml_pkg::FUNC_READ, 32'hFFFF_FFFF, -1, 1023, 1'b1, '0));
    // first hour opens with the temperature extremes
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, BASE_HOUR, 32767, 0, 1'b1,
                             report_word(0, 0, 0, 0, 0, 0, 0, BASE_HOUR, 1)));
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, BASE_HOUR, -32768, 1023, 1'b1,
                             report_word(0, 0, 0, 0, 0, 0, 0, BASE_HOUR, 2)));
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, BASE_HOUR, 0, 0));
    // next hour closes it: mean of -1/3 truncates to zero
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, BASE_HOUR + hmml_pkg::HOUR_SECONDS, 250, 0,
                             1'b1, report_word(1, -32768, 32767, 0, 0, 1, 0, BASE_HOUR, 1)));
    steps.push_back(stim_row(hmml_pkg::FUNC_READ, 32'd0, 0, 0, 1'b1,
                             report_word(0, -32768, 32767, 0, 1, 1, 0, BASE_HOUR, 1)));
    // slot at the held count is out of range
    steps.push_back(stim_row(hmml_pkg::FUNC_READ, 32'd0, 0, 1, 1'b1,
                             report_word(0, 0, 0, 0, 0, 1, 0, BASE_HOUR, 1)));
    // three-hour step gets copies, an earlier tag gets none
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, BASE_HOUR + 4 * hmml_pkg::HOUR_SECONDS,
                             -5, 0));
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, BASE_HOUR + 2 * hmml_pkg::HOUR_SECONDS,
                             7, 0));
    steps.push_back(stim_row(hmml_pkg::FUNC_READ, 32'd0, 0, 3));
    // tag zero closes the hour, latest time wraps, then the next zero and a real tag close nothing
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, 32'd0, 100, 0));
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, 32'd0, 3, 0));
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, BASE_HOUR + 10 * hmml_pkg::HOUR_SECONDS,
                             1, 0));
    // huge gap fills the whole ring
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, 32'hFFFF_FFFF, -1, 0));
    steps.push_back(stim_row(hmml_pkg::FUNC_READ, 32'd0, 0, 1023));
    // earlier tag on a full ring, then a step shorter than an hour
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, 32'd1, 9, 0));
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, 32'd2, 11, 0));
    steps.push_back(stim_row(hmml_pkg::FUNC_READ, 32'd0, 0, 0));
    steps.push_back(stim_row(hmml_pkg::FUNC_READ, 32'd0, 0, 5));
    steps.push_back(stim_row(hmml_pkg::FUNC_ADD, 32'd3602, -300, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    idle_on = 1'b1;
    foreach (steps[n]) send_word(steps[n].w, steps[n].pinned, steps[n].want);

    // random phases, each under its own sentinel pair; the last one runs without idling
    for (p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_sentinels(16'sh8000, 16'sh7FFF);
        2: set_sentinels(16'sh0000, 16'sh0000);
        4: set_sentinels(hmml_pkg::MIN_SENTINEL_RST, hmml_pkg::MAX_SENTINEL_RST);
        default: set_sentinels(16'($urandom), 16'($urandom));
      endcase
      idle_on = (p != N_PHASES - 1);
      repeat (PHASE_WORDS) send_random();
    end

    drain_words();
    repeat (64) @(posedge clk);
    if (n_fail == 0 && due_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/hmml_pkg.sv
rtl/hmml_ram.sv
rtl/hmml_dp.sv
rtl/hmml_ctrl.sv
rtl/hourly_min_max_mean_logger.sv
bench/hourly_min_max_mean_logger_test.sv
